/* design/mlpq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and codes for the multi-level priority queue.
// ----------------------------------------------------------------------------
package mlpq_pkg;

    typedef logic               t_req_type;
    typedef logic        [1:0]  t_level;
    typedef logic signed [31:0] t_word;
    typedef logic        [1:0]  t_status;

    localparam t_req_type REQ_INSERT = 1'b0;
    localparam t_req_type REQ_DELETE = 1'b1;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch the accepted request
        logic execute;     // perform insert or delete
        logic load_value;  // move memory read data into the result
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic del_hit;     // a delete found a non-empty level
    } t_dp_stat;

endpackage

`default_nettype wire

/* design/mlpq_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlpq_req_if / mlpq_res_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface mlpq_req_if;
    import mlpq_pkg::*;

    logic      valid;
    logic      ready;
    t_req_type req_type;
    t_level    level;
    t_word     value_in;

    modport source (output valid, output req_type, output level, output value_in,
                    input ready);
    modport sink   (input valid, input req_type, input level, input value_in,
                    output ready);
endinterface

interface mlpq_res_if;
    import mlpq_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_word   value_out;
    t_level  served_level;

    modport source (output valid, output status, output value_out,
                    output served_level, input ready);
    modport sink   (input valid, input status, input value_out,
                    input served_level, output ready);
endinterface

`default_nettype wire

/* design/mlpq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlpq_ctrl
// Sequencer: accept, execute, optional memory read, present result.
// ----------------------------------------------------------------------------
module mlpq_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mlpq_pkg::t_ctrl_cmd      o_cmd,
    input  wire mlpq_pkg::t_dp_stat  i_stat
);
    import mlpq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = i_stat.del_hit ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = (r_state == S_OUT);
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute    = (r_state == S_EXEC);
    assign o_cmd.load_value = (r_state == S_READ);

endmodule

`default_nettype wire

/* design/mlpq_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlpq_dp
// Per-level circular buffers in one shared memory, level priority encoder
// and result registers.
// ----------------------------------------------------------------------------
module mlpq_dp #(
    parameter int LEVELS = 3,
    parameter int DEPTH  = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mlpq_pkg::t_ctrl_cmd  i_cmd,
    output mlpq_pkg::t_dp_stat        o_stat,
    input  wire mlpq_pkg::t_req_type  i_req_type,
    input  wire mlpq_pkg::t_level     i_level,
    input  wire mlpq_pkg::t_word      i_value_in,
    output mlpq_pkg::t_status         o_status,
    output mlpq_pkg::t_word           o_value_out,
    output mlpq_pkg::t_level          o_served_level
);
    import mlpq_pkg::*;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(LEVELS * DEPTH);
    localparam int ENTRIES = LEVELS * DEPTH;

    // latched request
    t_req_type r_req_type;
    t_level    r_level;
    t_word     r_value_in;

    // per-level queue state
    logic [PW-1:0] r_head  [LEVELS];
    logic [PW-1:0] r_tail  [LEVELS];
    logic [CW-1:0] r_count [LEVELS];

    logic [31:0] r_mem [ENTRIES];
    logic [31:0] r_rd_data;

    t_status r_status;
    t_word   r_value_out;
    t_level  r_served;

    logic [LW-1:0] w_ins_idx;
    logic          w_lvl_ok;
    logic          w_ins_ok;
    logic          w_hit;
    logic [LW-1:0] w_sel;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;
    logic          w_is_del;
    logic          w_inv_bad;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_is_del  = (r_req_type == REQ_DELETE);
    assign w_ins_idx = LW'(r_level);
    assign w_lvl_ok  = (32'(r_level) < 32'(LEVELS));
    assign w_ins_ok  = w_lvl_ok && (r_count[w_ins_idx] != CW'(DEPTH));

    // lowest-numbered non-empty level wins
    always_comb begin
        w_hit = 1'b0;
        w_sel = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_hit = 1'b1;
                w_sel = LW'(i);
            end
        end
    end

    assign w_wr_addr = AW'(32'(w_ins_idx) * DEPTH + 32'(r_tail[w_ins_idx]));
    assign w_rd_addr = AW'(32'(w_sel) * DEPTH + 32'(r_head[w_sel]));

    assign o_stat.del_hit = w_is_del && w_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_type <= i_req_type;
            r_level    <= i_level;
            r_value_in <= i_value_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            if (!w_is_del) begin
                if (w_ins_ok) begin
                    r_tail[w_ins_idx]  <= next_slot(r_tail[w_ins_idx]);
                    r_count[w_ins_idx] <= r_count[w_ins_idx] + 1'b1;
                end
            end else if (w_hit) begin
                r_head[w_sel]  <= next_slot(r_head[w_sel]);
                r_count[w_sel] <= r_count[w_sel] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && !w_is_del && w_ins_ok) begin
            r_mem[w_wr_addr] <= r_value_in;
        end
        if (i_cmd.execute && w_is_del) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_value_out <= '0;
            r_served    <= '0;
            if (!w_is_del) begin
                r_status <= w_ins_ok ? ST_OK : ST_FULL;
            end else if (w_hit) begin
                r_status <= ST_OK;
                r_served <= 2'(w_sel);
            end else begin
                r_status <= ST_EMPTY;
            end
        end else if (i_cmd.load_value) begin
            r_value_out <= r_rd_data;
        end
    end

    assign o_status       = r_status;
    assign o_value_out    = r_value_out;
    assign o_served_level = r_served;

    // queue invariants: count within depth, tail = head + count (mod depth)
    always_comb begin
        logic [31:0] sum;
        w_inv_bad = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            sum = 32'(r_head[i]) + 32'(r_count[i]);
            if (sum >= 32'(DEPTH)) sum = sum - 32'(DEPTH);
            if (32'(r_count[i]) > 32'(DEPTH) || sum != 32'(r_tail[i])) begin
                w_inv_bad = 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_queue_invariant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_inv_bad)
        else $error("level count and pointers disagree");

    a_full_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && !w_is_del) |=> (r_value_out == '0 && r_served == '0))
        else $error("insert result carries value or level");

    a_hit_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && w_is_del && w_hit) |=>
            (r_count[$past(w_sel)] == $past(r_count[w_sel]) - 1'b1))
        else $error("delete did not remove exactly one entry");

    a_empty_means_all_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.execute && w_is_del && !w_hit) |=> (r_status == ST_EMPTY))
        else $error("empty delete reported wrong status");
`endif

endmodule

`default_nettype wire

/* design/multi_level_priority_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multi_level_priority_queue
// Strict-priority queue: one circular FIFO per level, level 0 served first.
//
//  channel | dir | payload                              | handshake
//  i_req   | in  | req_type, level, value_in            | valid/ready
//  o_res   | out | status, value_out, served_level      | valid/ready
//
// An accepted item is latched, executed in the EXEC state and its result is
// presented in the OUT state; an insert or an empty delete goes from EXEC
// straight to OUT. A delete that finds an entry passes through the READ state
// for the registered read of the shared entry memory. A result waits in OUT.
// One item is in flight at a time; i_req.ready stays low until o_res is taken.
// Synchronous active-low reset clears pointers and counts; entry memory is
// not cleared, and read data reaches o_res only where the count says it was written.
// ----------------------------------------------------------------------------
module multi_level_priority_queue #(
    parameter int LEVELS = 3,
    parameter int DEPTH  = 8
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mlpq_req_if.sink    i_req,
    mlpq_res_if.source  o_res
);
    import mlpq_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    mlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    mlpq_dp #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req.req_type),
        .i_level        (i_req.level),
        .i_value_in     (i_req.value_in),
        .o_status       (o_res.status),
        .o_value_out    (o_res.value_out),
        .o_served_level (o_res.served_level)
    );

endmodule

`default_nettype wire
